@@ hdl/htsr_pkg.sv @@
// ============================================================================
// htsr_pkg
// Shared types, character codes and helpers for the HTML tag segment
// recognizer.
// ============================================================================
package htsr_pkg;

   // Default longest segment, in bytes
   localparam int MAX_SEGMENT_LEN_DEF = 4096;

   // Fixed widths of the result fields
   localparam int LEN_W = 13;
   localparam int OFS_W = 12;

   // Character codes
   localparam logic [7:0] CHAR_GT        = 8'h3E;  // '>'
   localparam logic [7:0] CHAR_LT        = 8'h3C;  // '<'
   localparam logic [7:0] CHAR_SLASH     = 8'h2F;  // '/'
   localparam logic [7:0] CHAR_CASE_BIT  = 8'h20;  // folds upper case to lower
   localparam logic [7:0] CHAR_LOWER_A   = 8'h61;
   localparam logic [7:0] CHAR_LOWER_Z   = 8'h7A;
   localparam logic [7:0] CHAR_SPACE     = 8'h20;
   localparam logic [7:0] CHAR_TAB       = 8'h09;
   localparam logic [7:0] CHAR_LF        = 8'h0A;
   localparam logic [7:0] CHAR_VT        = 8'h0B;
   localparam logic [7:0] CHAR_FF        = 8'h0C;
   localparam logic [7:0] CHAR_CR        = 8'h0D;

   // Parse phase
   typedef enum logic [2:0] {
      PH_START,
      PH_NAME_FIRST,
      PH_NAME,
      PH_ATTRS,
      PH_TRAIL,
      PH_FAIL
   } phase_type;

   // Phase and single-bit flags of the parser
   typedef struct packed {
      phase_type phase;
      logic      leading_slash;
      logic      ended_self_closed;
      logic      attr_seen;
      logic      slash_waiting;
   } flags_type;

   // One result item
   typedef struct packed {
      logic             matched;
      logic             closing_tag;
      logic             slash_close;
      logic [LEN_W-1:0] name_length;
      logic             attrs_present;
      logic [OFS_W-1:0] attrs_offset;
      logic [LEN_W-1:0] attrs_length;
      logic [LEN_W-1:0] trail_offset;
      logic [LEN_W-1:0] trail_length;
   } result_type;

   localparam flags_type FLAGS_RESET = '{
      phase:             PH_START,
      leading_slash:     1'b0,
      ended_self_closed: 1'b0,
      attr_seen:         1'b0,
      slash_waiting:     1'b0
   };

   function automatic logic is_letter(input logic [7:0] b);
      logic [7:0] lc;
      lc = b | CHAR_CASE_BIT;
      return (lc >= CHAR_LOWER_A) && (lc <= CHAR_LOWER_Z);
   endfunction

   function automatic logic is_space(input logic [7:0] b);
      return b inside {CHAR_SPACE, CHAR_TAB, CHAR_LF, CHAR_VT, CHAR_FF, CHAR_CR};
   endfunction

endpackage

@@ hdl/htsr_req_if.sv @@
// ============================================================================
// htsr_req_if
// Byte channel into the recognizer: at most one segment byte per transfer.
// ============================================================================
interface htsr_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       byte_valid;
   logic       segment_end;

   modport source (
      output valid, data_byte, byte_valid, segment_end,
      input  ready
   );

   modport sink (
      input  valid, data_byte, byte_valid, segment_end,
      output ready
   );
endinterface

@@ hdl/htsr_rsp_if.sv @@
// ============================================================================
// htsr_rsp_if
// Result channel out of the recognizer: one segment summary per transfer.
// ============================================================================
interface htsr_rsp_if;
   logic                       valid;
   logic                       ready;
   logic                       matched;
   logic                       closing_tag;
   logic                       slash_close;
   logic [htsr_pkg::LEN_W-1:0] name_length;
   logic                       attrs_present;
   logic [htsr_pkg::OFS_W-1:0] attrs_offset;
   logic [htsr_pkg::LEN_W-1:0] attrs_length;
   logic [htsr_pkg::LEN_W-1:0] trail_offset;
   logic [htsr_pkg::LEN_W-1:0] trail_length;

   modport source (
      output valid, matched, closing_tag, slash_close, name_length,
             attrs_present, attrs_offset, attrs_length, trail_offset,
             trail_length,
      input  ready
   );

   modport sink (
      input  valid, matched, closing_tag, slash_close, name_length,
             attrs_present, attrs_offset, attrs_length, trail_offset,
             trail_length,
      output ready
   );
endinterface

@@ hdl/htsr_step.sv @@
// ============================================================================
// htsr_step
// Combinational parser step: advances the parse state by one byte and forms
// the segment summary from the advanced state.
// ============================================================================
module htsr_step #(
   parameter int MAX_SEGMENT_LEN = htsr_pkg::MAX_SEGMENT_LEN_DEF,
   localparam int POS_W = $clog2(MAX_SEGMENT_LEN + 1)
) (
   input  htsr_pkg::flags_type  flags,
   input  logic [POS_W-1:0]     position,
   input  logic [POS_W-1:0]     name_count,
   input  logic [POS_W-1:0]     attr_start,
   input  logic [POS_W-1:0]     trail_start,
   input  logic [7:0]           data_byte,
   input  logic                 byte_valid,
   output htsr_pkg::flags_type  flags_nxt,
   output logic [POS_W-1:0]     position_nxt,
   output logic [POS_W-1:0]     name_count_nxt,
   output logic [POS_W-1:0]     attr_start_nxt,
   output logic [POS_W-1:0]     trail_start_nxt,
   output htsr_pkg::result_type result
);

   localparam int CALC_W = (POS_W > htsr_pkg::LEN_W) ? POS_W : htsr_pkg::LEN_W;

   logic             is_gt;
   logic             is_slash;
   logic [POS_W-1:0] pos_next;

   assign is_gt    = (data_byte == htsr_pkg::CHAR_GT);
   assign is_slash = (data_byte == htsr_pkg::CHAR_SLASH);
   assign pos_next = position + POS_W'(1);

   // Next state
   always_comb begin
      flags_nxt       = flags;
      position_nxt    = position;
      name_count_nxt  = name_count;
      attr_start_nxt  = attr_start;
      trail_start_nxt = trail_start;

      if (byte_valid && (flags.phase != htsr_pkg::PH_FAIL)) begin
         if (position == POS_W'(MAX_SEGMENT_LEN)) begin
            flags_nxt.phase = htsr_pkg::PH_FAIL;
         end else begin
            position_nxt = pos_next;
            case (flags.phase)
               htsr_pkg::PH_START: begin
                  if (is_slash) begin
                     flags_nxt.leading_slash = 1'b1;
                     flags_nxt.phase         = htsr_pkg::PH_NAME_FIRST;
                  end else if (htsr_pkg::is_letter(data_byte)) begin
                     name_count_nxt  = POS_W'(1);
                     flags_nxt.phase = htsr_pkg::PH_NAME;
                  end else begin
                     flags_nxt.phase = htsr_pkg::PH_FAIL;
                  end
               end
               htsr_pkg::PH_NAME_FIRST: begin
                  if (htsr_pkg::is_letter(data_byte)) begin
                     name_count_nxt  = POS_W'(1);
                     flags_nxt.phase = htsr_pkg::PH_NAME;
                  end else begin
                     flags_nxt.phase = htsr_pkg::PH_FAIL;
                  end
               end
               htsr_pkg::PH_NAME: begin
                  if (flags.slash_waiting) begin
                     flags_nxt.slash_waiting = 1'b0;
                     if (is_gt) begin
                        flags_nxt.ended_self_closed = 1'b1;
                        trail_start_nxt             = pos_next;
                        flags_nxt.phase             = htsr_pkg::PH_TRAIL;
                     end else begin
                        // the span opens at the held slash
                        flags_nxt.attr_seen = 1'b1;
                        attr_start_nxt      = position - POS_W'(1);
                        flags_nxt.phase     = htsr_pkg::PH_ATTRS;
                        if (is_slash) begin
                           flags_nxt.slash_waiting = 1'b1;
                        end
                     end
                  end else if (is_gt) begin
                     trail_start_nxt = pos_next;
                     flags_nxt.phase = htsr_pkg::PH_TRAIL;
                  end else if (is_slash) begin
                     flags_nxt.slash_waiting = 1'b1;
                  end else if (htsr_pkg::is_space(data_byte)) begin
                     flags_nxt.attr_seen = 1'b1;
                     attr_start_nxt      = position;
                     flags_nxt.phase     = htsr_pkg::PH_ATTRS;
                  end else begin
                     name_count_nxt = name_count + POS_W'(1);
                  end
               end
               htsr_pkg::PH_ATTRS: begin
                  flags_nxt.slash_waiting = 1'b0;
                  if (is_gt) begin
                     flags_nxt.ended_self_closed = flags.slash_waiting;
                     trail_start_nxt             = pos_next;
                     flags_nxt.phase             = htsr_pkg::PH_TRAIL;
                  end else if (is_slash) begin
                     flags_nxt.slash_waiting = 1'b1;
                  end
               end
               htsr_pkg::PH_TRAIL: begin
                  if (data_byte == htsr_pkg::CHAR_LT) begin
                     flags_nxt.phase = htsr_pkg::PH_FAIL;
                  end
               end
               default: begin
                  flags_nxt.phase = htsr_pkg::PH_FAIL;
               end
            endcase
         end
      end
   end

   // Segment summary from the advanced state
   logic [POS_W-1:0]  close_len;
   logic [POS_W-1:0]  attr_span_len;
   logic [POS_W-1:0]  trail_len;
   logic [CALC_W-1:0] name_wide;
   logic [CALC_W-1:0] attr_ofs_wide;
   logic [CALC_W-1:0] attr_len_wide;
   logic [CALC_W-1:0] trail_ofs_wide;
   logic [CALC_W-1:0] trail_len_wide;

   always_comb begin
      close_len      = flags_nxt.ended_self_closed ? POS_W'(2) : POS_W'(1);
      attr_span_len  = trail_start_nxt - close_len - attr_start_nxt;
      trail_len      = position_nxt - trail_start_nxt;
      name_wide      = CALC_W'(name_count_nxt);
      attr_ofs_wide  = CALC_W'(attr_start_nxt);
      attr_len_wide  = CALC_W'(attr_span_len);
      trail_ofs_wide = CALC_W'(trail_start_nxt);
      trail_len_wide = CALC_W'(trail_len);

      result = '0;
      if (flags_nxt.phase == htsr_pkg::PH_TRAIL) begin
         result.matched      = 1'b1;
         result.closing_tag  = flags_nxt.leading_slash;
         result.slash_close  = flags_nxt.ended_self_closed;
         result.name_length  = name_wide[htsr_pkg::LEN_W-1:0];
         if (flags_nxt.attr_seen) begin
            result.attrs_present = 1'b1;
            result.attrs_offset  = attr_ofs_wide[htsr_pkg::OFS_W-1:0];
            result.attrs_length  = attr_len_wide[htsr_pkg::LEN_W-1:0];
         end
         result.trail_offset = trail_ofs_wide[htsr_pkg::LEN_W-1:0];
         result.trail_length = trail_len_wide[htsr_pkg::LEN_W-1:0];
      end
   end

endmodule

@@ hdl/html_tag_segment_recognizer.sv @@
// ============================================================================
// html_tag_segment_recognizer
// Checks the bytes after a '<' against the tag pattern and reports one
// summary per segment: match, closing and self-closing flags, name,
// attribute and trailing-text spans.
// ============================================================================
//
//  channel       | direction | moves
//  --------------+-----------+----------------------------------------------
//  req_channel   | in        | one segment byte, byte-present flag, end mark
//  rsp_channel   | out       | one segment summary per end-marked transfer
//
//  One byte per cycle unless stalled; a new transfer may be taken in every
//  cycle. One pass of the step logic advances the parse counters and flags.
//  A summary appears on rsp_channel the cycle after its end-marked transfer.
//  req_channel.ready drops only while a summary is held and rsp_channel is
//  stalled, and is high again in the cycle the summary drains.
//  Reset (synchronous, active high) restarts the parse and empties the output.
//
module html_tag_segment_recognizer #(
   parameter int MAX_SEGMENT_LEN = htsr_pkg::MAX_SEGMENT_LEN_DEF
) (
   input logic        clock,
   input logic        reset,
   htsr_req_if.sink   req_channel,
   htsr_rsp_if.source rsp_channel
);

   localparam int POS_W = $clog2(MAX_SEGMENT_LEN + 1);

   // Parse state
   htsr_pkg::flags_type flags_ff, flags_in;
   logic [POS_W-1:0]    position_ff, position_in;
   logic [POS_W-1:0]    name_count_ff, name_count_in;
   logic [POS_W-1:0]    attr_start_ff, attr_start_in;
   logic [POS_W-1:0]    trail_start_ff, trail_start_in;

   // Step outputs
   htsr_pkg::flags_type  flags_nxt;
   logic [POS_W-1:0]     position_nxt;
   logic [POS_W-1:0]     name_count_nxt;
   logic [POS_W-1:0]     attr_start_nxt;
   logic [POS_W-1:0]     trail_start_nxt;
   htsr_pkg::result_type step_result;

   // Output register
   logic                 rsp_valid_ff, rsp_valid_in;
   htsr_pkg::result_type result_ff, result_in;

   logic req_xfer;
   logic seg_done;

   // Take a byte whenever the output register is free or draining this cycle
   assign req_channel.ready = !rsp_valid_ff || rsp_channel.ready;
   assign req_xfer          = req_channel.valid && req_channel.ready;
   assign seg_done          = req_xfer && req_channel.segment_end;

   htsr_step #(
      .MAX_SEGMENT_LEN (MAX_SEGMENT_LEN)
   ) u_step (
      .flags           (flags_ff),
      .position        (position_ff),
      .name_count      (name_count_ff),
      .attr_start      (attr_start_ff),
      .trail_start     (trail_start_ff),
      .data_byte       (req_channel.data_byte),
      .byte_valid      (req_channel.byte_valid),
      .flags_nxt       (flags_nxt),
      .position_nxt    (position_nxt),
      .name_count_nxt  (name_count_nxt),
      .attr_start_nxt  (attr_start_nxt),
      .trail_start_nxt (trail_start_nxt),
      .result          (step_result)
   );

   // Advance the parse state on a transfer; clear it when the segment ends
   always_comb begin
      flags_in       = flags_ff;
      position_in    = position_ff;
      name_count_in  = name_count_ff;
      attr_start_in  = attr_start_ff;
      trail_start_in = trail_start_ff;
      if (seg_done) begin
         flags_in       = htsr_pkg::FLAGS_RESET;
         position_in    = '0;
         name_count_in  = '0;
         attr_start_in  = '0;
         trail_start_in = '0;
      end else if (req_xfer) begin
         flags_in       = flags_nxt;
         position_in    = position_nxt;
         name_count_in  = name_count_nxt;
         attr_start_in  = attr_start_nxt;
         trail_start_in = trail_start_nxt;
      end
   end

   // Load the summary on the end-marked transfer; drop it once taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      result_in    = result_ff;
      if (seg_done) begin
         rsp_valid_in = 1'b1;
         result_in    = step_result;
      end else if (rsp_channel.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         flags_ff       <= htsr_pkg::FLAGS_RESET;
         position_ff    <= '0;
         name_count_ff  <= '0;
         attr_start_ff  <= '0;
         trail_start_ff <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         flags_ff       <= flags_in;
         position_ff    <= position_in;
         name_count_ff  <= name_count_in;
         attr_start_ff  <= attr_start_in;
         trail_start_ff <= trail_start_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // Summary payload needs no reset
   always_ff @(posedge clock) begin
      result_ff <= result_in;
   end

   assign rsp_channel.valid         = rsp_valid_ff;
   assign rsp_channel.matched       = result_ff.matched;
   assign rsp_channel.closing_tag   = result_ff.closing_tag;
   assign rsp_channel.slash_close   = result_ff.slash_close;
   assign rsp_channel.name_length   = result_ff.name_length;
   assign rsp_channel.attrs_present = result_ff.attrs_present;
   assign rsp_channel.attrs_offset  = result_ff.attrs_offset;
   assign rsp_channel.attrs_length  = result_ff.attrs_length;
   assign rsp_channel.trail_offset  = result_ff.trail_offset;
   assign rsp_channel.trail_length  = result_ff.trail_length;

endmodule

@@ verif/html_tag_segment_recognizer_test.sv @@
`timescale 1ns / 1ps
// ============================================================================
// html_tag_segment_recognizer_test
// Self-checking bench for the tag segment recognizer. Segments are streamed
// one byte per transfer. Most are well-formed tags with random content, and
// the rest are noise, truncated or corrupted segments. Each accepted byte
// advances a parse tracker that predicts the per-segment summary, and every
// summary that leaves the block is compared field by field, in order.
// ============================================================================
module html_tag_segment_recognizer_test;

   typedef logic [7:0] byte_queue_type[$];

   localparam int LEN_W        = htsr_pkg::LEN_W;
   localparam int OFS_W        = htsr_pkg::OFS_W;
   localparam int SEG_LIMIT    = htsr_pkg::MAX_SEGMENT_LEN_DEF;
   localparam int RANDOM_ITEMS = 1300;
   localparam int LONG_HOLD    = 400;      // receiver stall that fills the block
   localparam int DRAIN_CYCLES = 20;       // summary lands the cycle after its end-marked transfer
   localparam int PRINT_CAP    = 100;      // keep the log readable on a broken build
   // Slowest legal run: ~1.5k transfers, each with at most the longest pick_gap
   // sender gap, the longest receiver stall on the couple hundred summaries, plus
   // the long hold. CYCLE_LIMIT lies far above that, so it leaves a wide margin.
   localparam int CYCLE_LIMIT  = 1000000;

   // -------------------------------------------------------------------------
   // Parse tracker: follows the segment byte by byte and queues the summary
   // that each end-marked transfer must produce.
   // -------------------------------------------------------------------------
   class segment_scoreboard_type;
      htsr_pkg::phase_type  phase;
      logic [LEN_W-1:0]     bytes_taken;
      logic [LEN_W-1:0]     name_bytes;
      logic [OFS_W-1:0]     attr_at;
      logic [LEN_W-1:0]     trail_at;
      bit                   lead_slash;
      bit                   self_closed;
      bit                   attrs_begun;
      bit                   slash_held;
      htsr_pkg::result_type expected_summaries[$];
      int                   errors;

      function new();
         restart();
         errors = 0;
      endfunction

      function void restart();
         phase       = htsr_pkg::PH_START;
         bytes_taken = '0;
         name_bytes  = '0;
         attr_at     = '0;
         trail_at    = '0;
         lead_slash  = 1'b0;
         self_closed = 1'b0;
         attrs_begun = 1'b0;
         slash_held  = 1'b0;
      endfunction

      static function bit is_alpha(logic [7:0] b);
         logic [7:0] folded;
         folded = b | htsr_pkg::CHAR_CASE_BIT;
         return (folded >= htsr_pkg::CHAR_LOWER_A) && (folded <= htsr_pkg::CHAR_LOWER_Z);
      endfunction

      static function bit is_blank(logic [7:0] b);
         case (b)
            htsr_pkg::CHAR_SPACE, htsr_pkg::CHAR_TAB, htsr_pkg::CHAR_LF,
            htsr_pkg::CHAR_VT, htsr_pkg::CHAR_FF, htsr_pkg::CHAR_CR: return 1'b1;
            default: return 1'b0;
         endcase
      endfunction

      function void close_tag(logic [LEN_W-1:0] pos);
         trail_at = pos + 1'b1;
         phase    = htsr_pkg::PH_TRAIL;
      endfunction

      // plain byte inside the attribute span
      function void attr_step(logic [7:0] b, logic [LEN_W-1:0] pos);
         if (b == htsr_pkg::CHAR_GT) begin
            close_tag(pos);
         end else if (b == htsr_pkg::CHAR_SLASH) begin
            slash_held = 1'b1;
         end
      endfunction

      function void advance(logic [7:0] b);
         logic [LEN_W-1:0] pos;
         if (phase == htsr_pkg::PH_FAIL) return;
         if (bytes_taken >= SEG_LIMIT) begin
            phase = htsr_pkg::PH_FAIL;
            return;
         end
         pos         = bytes_taken;
         bytes_taken = pos + 1'b1;
         case (phase)
            htsr_pkg::PH_START: begin
               if (b == htsr_pkg::CHAR_SLASH) begin
                  lead_slash = 1'b1;
                  phase      = htsr_pkg::PH_NAME_FIRST;
               end else if (is_alpha(b)) begin
                  name_bytes = LEN_W'(1);
                  phase      = htsr_pkg::PH_NAME;
               end else begin
                  phase = htsr_pkg::PH_FAIL;
               end
            end
            htsr_pkg::PH_NAME_FIRST: begin
               if (is_alpha(b)) begin
                  name_bytes = LEN_W'(1);
                  phase      = htsr_pkg::PH_NAME;
               end else begin
                  phase = htsr_pkg::PH_FAIL;
               end
            end
            htsr_pkg::PH_NAME: begin
               if (slash_held) begin
                  slash_held = 1'b0;
                  if (b == htsr_pkg::CHAR_GT) begin
                     self_closed = 1'b1;
                     close_tag(pos);
                  end else begin
                     // the held slash opens the attribute span
                     attrs_begun = 1'b1;
                     attr_at     = pos[OFS_W-1:0] - 1'b1;
                     phase       = htsr_pkg::PH_ATTRS;
                     attr_step(b, pos);
                  end
               end else if (b == htsr_pkg::CHAR_GT) begin
                  close_tag(pos);
               end else if (b == htsr_pkg::CHAR_SLASH) begin
                  slash_held = 1'b1;
               end else if (is_blank(b)) begin
                  attrs_begun = 1'b1;
                  attr_at     = pos[OFS_W-1:0];
                  phase       = htsr_pkg::PH_ATTRS;
               end else begin
                  name_bytes = name_bytes + 1'b1;
               end
            end
            htsr_pkg::PH_ATTRS: begin
               if (slash_held && b == htsr_pkg::CHAR_GT) begin
                  slash_held  = 1'b0;
                  self_closed = 1'b1;
                  close_tag(pos);
               end else begin
                  slash_held = 1'b0;
                  attr_step(b, pos);
               end
            end
            htsr_pkg::PH_TRAIL: begin
               if (b == htsr_pkg::CHAR_LT) phase = htsr_pkg::PH_FAIL;
            end
            default: phase = htsr_pkg::PH_FAIL;
         endcase
      endfunction

      // note one accepted transfer on the byte channel
      function void take_item(logic [7:0] b, bit has_byte, bit last);
         htsr_pkg::result_type summary;
         logic [LEN_W-1:0]     close_len;
         if (has_byte) advance(b);
         if (!last) return;
         summary = '0;
         if (phase == htsr_pkg::PH_TRAIL) begin
            close_len             = self_closed ? LEN_W'(2) : LEN_W'(1);
            summary.matched       = 1'b1;
            summary.closing_tag   = lead_slash;
            summary.slash_close   = self_closed;
            summary.name_length   = name_bytes;
            if (attrs_begun) begin
               summary.attrs_present = 1'b1;
               summary.attrs_offset  = attr_at;
               summary.attrs_length  = trail_at - close_len - LEN_W'(attr_at);
            end
            summary.trail_offset = trail_at;
            summary.trail_length = bytes_taken - trail_at;
         end
         expected_summaries.push_back(summary);
         restart();
      endfunction

      task report(string msg);
         errors++;
         if (errors <= PRINT_CAP) $display("[%0t] MISMATCH: %s", $time, msg);
      endtask

      task compare(string field, logic [LEN_W-1:0] got, logic [LEN_W-1:0] want);
         if (got !== want) report($sformatf("%s got %0d, want %0d", field, got, want));
      endtask

      // check one summary taken from the result channel
      task check_summary(htsr_pkg::result_type got);
         htsr_pkg::result_type want;
         if (expected_summaries.size() == 0) begin
            report("summary arrived with no segment outstanding");
            return;
         end
         want = expected_summaries.pop_front();
         compare("matched",       LEN_W'(got.matched),       LEN_W'(want.matched));
         compare("closing_tag",   LEN_W'(got.closing_tag),   LEN_W'(want.closing_tag));
         compare("slash_close",   LEN_W'(got.slash_close),   LEN_W'(want.slash_close));
         compare("name_length",   got.name_length,           want.name_length);
         compare("attrs_present", LEN_W'(got.attrs_present), LEN_W'(want.attrs_present));
         compare("attrs_offset",  LEN_W'(got.attrs_offset),  LEN_W'(want.attrs_offset));
         compare("attrs_length",  got.attrs_length,          want.attrs_length);
         compare("trail_offset",  got.trail_offset,          want.trail_offset);
         compare("trail_length",  got.trail_length,          want.trail_length);
      endtask
   endclass

   logic clock;
   logic reset;

   htsr_req_if req_bus ();
   htsr_rsp_if rsp_bus ();

   html_tag_segment_recognizer i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_channel (req_bus),
      .rsp_channel (rsp_bus)
   );

   segment_scoreboard_type tracker = new();

   bit quiet          = 1'b0;   // suppress idling on both sides
   bit long_hold_req  = 1'b0;   // ask the receiver for one long stall
   int sent_items     = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Gap length, drawn from three ranges: mostly the shortest, sometimes the middle one, rarely the longest.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 80) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [7:0] random_letter();
      logic [7:0] base;
      base = $urandom_range(0, 1) ? htsr_pkg::CHAR_LOWER_A :
                                    (htsr_pkg::CHAR_LOWER_A & ~htsr_pkg::CHAR_CASE_BIT);
      return base + 8'($urandom_range(0, 25));
   endfunction

   function automatic logic [7:0] random_except(logic [7:0] banned);
      logic [7:0] v;
      do v = 8'($urandom); while (v == banned);
      return v;
   endfunction

   // Name bytes: mostly letters, otherwise anything that does not end the name.
   function automatic logic [7:0] name_byte();
      logic [7:0] v;
      if ($urandom_range(0, 3) != 0) return random_letter();
      do v = 8'($urandom);
      while (v == htsr_pkg::CHAR_SLASH || v == htsr_pkg::CHAR_GT ||
             segment_scoreboard_type::is_blank(v));
      return v;
   endfunction

   // Build a well-formed segment: [/] name [attrs] > or /> [trail]
   function automatic byte_queue_type build_tag();
      byte_queue_type s;
      int             n;
      bit             with_attrs;
      logic [7:0]     blanks[6];
      blanks = '{htsr_pkg::CHAR_SPACE, htsr_pkg::CHAR_TAB, htsr_pkg::CHAR_LF,
                 htsr_pkg::CHAR_VT, htsr_pkg::CHAR_FF, htsr_pkg::CHAR_CR};
      with_attrs = 1'b1;
      if ($urandom_range(0, 3) == 0) s.push_back(htsr_pkg::CHAR_SLASH);
      s.push_back(random_letter());
      n = $urandom_range(0, 6);
      repeat (n) s.push_back(name_byte());
      case ($urandom_range(0, 2))
         1: s.push_back(blanks[$urandom_range(0, 5)]);
         2: begin
            s.push_back(htsr_pkg::CHAR_SLASH);
            s.push_back(random_except(htsr_pkg::CHAR_GT));
         end
         default: with_attrs = 1'b0;
      endcase
      if (with_attrs) begin
         n = $urandom_range(0, 8);
         repeat (n) s.push_back($urandom_range(0, 3) == 0 ? htsr_pkg::CHAR_SLASH :
                                random_except(htsr_pkg::CHAR_GT));
      end
      if ($urandom_range(0, 1)) s.push_back(htsr_pkg::CHAR_SLASH);
      s.push_back(htsr_pkg::CHAR_GT);
      n = $urandom_range(0, 5);
      repeat (n) s.push_back(random_except(htsr_pkg::CHAR_LT));
      return s;
   endfunction

   // Offer one transfer and hold it until accepted, then maybe idle a while.
   task automatic drive_item(logic [7:0] b, bit has_byte, bit last);
      req_bus.valid       <= 1'b1;
      req_bus.data_byte   <= b;
      req_bus.byte_valid  <= has_byte;
      req_bus.segment_end <= last;
      do @(posedge clock); while (!req_bus.ready);
      tracker.take_item(b, has_byte, last);
      if (has_byte || last) sent_items++;
      if (!quiet && $urandom_range(0, 4) == 0) begin
         req_bus.valid     <= 1'b0;
         req_bus.data_byte <= 8'($urandom);
         repeat (pick_gap()) @(posedge clock);
      end
   endtask

   // Stream a segment. Idle transfers may fall between bytes, and the end
   // mark may ride on a separate transfer with no byte.
   task automatic send_segment(byte_queue_type seg, bit end_without_byte);
      if (seg.size() == 0) begin
         drive_item(8'($urandom), 1'b0, 1'b1);
         return;
      end
      foreach (seg[i]) begin
         if (!quiet && $urandom_range(0, 11) == 0) drive_item(8'($urandom), 1'b0, 1'b0);
         drive_item(seg[i], 1'b1, (i == seg.size() - 1) && !end_without_byte);
      end
      if (end_without_byte) drive_item(8'($urandom), 1'b0, 1'b1);
   endtask

   // -------------------------------------------------------------------------
   // Result side: check each transfer, then pick the next ready value.
   // A requested long hold is counted down here, independent of the sender.
   // -------------------------------------------------------------------------
   initial begin : summary_sink
      int                   hold_left;
      bit                   long_hold_done;
      htsr_pkg::result_type got;
      hold_left      = 0;
      long_hold_done = 1'b0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_bus.valid && rsp_bus.ready) begin
            got.matched       = rsp_bus.matched;
            got.closing_tag   = rsp_bus.closing_tag;
            got.slash_close   = rsp_bus.slash_close;
            got.name_length   = rsp_bus.name_length;
            got.attrs_present = rsp_bus.attrs_present;
            got.attrs_offset  = rsp_bus.attrs_offset;
            got.attrs_length  = rsp_bus.attrs_length;
            got.trail_offset  = rsp_bus.trail_offset;
            got.trail_length  = rsp_bus.trail_length;
            tracker.check_summary(got);
         end
         if (long_hold_req && !long_hold_done) begin
            long_hold_done = 1'b1;
            hold_left      = LONG_HOLD;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else if (quiet || $urandom_range(0, 3) != 0) begin
            rsp_bus.ready <= 1'b1;
         end else begin
            hold_left      = pick_gap() - 1;
            rsp_bus.ready <= 1'b0;
         end
      end
   end

   // Hard stop in case the block wedges.
   initial begin : watchdog
      int cycles;
      cycles = 0;
      forever begin
         @(posedge clock);
         cycles++;
         if (cycles > CYCLE_LIMIT) begin
            $display("** html_tag_segment_recognizer: FAILED **");
            $finish;
         end
      end
   end

   // -------------------------------------------------------------------------
   // Stimulus
   // -------------------------------------------------------------------------
   initial begin : stimulus
      byte_queue_type seg;
      int             kind;
      int             n;
      int             seg_count;
      logic [7:0]     near_letters[6];
      // bytes just outside the letter ranges, and letters with the top bit set
      near_letters = '{8'h40, 8'h5B, 8'h60, 8'h7B, 8'hC1, 8'hFA};

      req_bus.valid       <= 1'b0;
      req_bus.data_byte   <= '0;
      req_bus.byte_valid  <= 1'b0;
      req_bus.segment_end <= 1'b0;
      reset               <= 1'b1;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // --- directed cases -----------------------------------------------
      // empty segment: end mark with no byte
      drive_item(8'($urandom), 1'b0, 1'b1);
      // plain tag with an idle transfer inside and the end mark on its own
      drive_item(htsr_pkg::CHAR_LOWER_A, 1'b1, 1'b0);
      drive_item(8'($urandom), 1'b0, 1'b0);
      drive_item(htsr_pkg::CHAR_GT, 1'b1, 1'b0);
      drive_item(8'($urandom), 1'b0, 1'b1);
      // closing, self-closed, upper-case name, trailing text
      seg = '{htsr_pkg::CHAR_SLASH, htsr_pkg::CHAR_LOWER_Z & ~htsr_pkg::CHAR_CASE_BIT,
              htsr_pkg::CHAR_SLASH, htsr_pkg::CHAR_GT, 8'h78};
      send_segment(seg, 1'b0);
      // slash after the name that is not followed by '>' opens the attributes
      seg = '{8'h70, htsr_pkg::CHAR_SLASH, 8'h71, htsr_pkg::CHAR_GT};
      send_segment(seg, 1'b0);
      // attribute span ends on a dangling slash: unclosed, no match
      seg = '{8'h69, htsr_pkg::CHAR_TAB, 8'h78, htsr_pkg::CHAR_SLASH};
      send_segment(seg, 1'b0);
      // '<' inside trailing text, and a top-bit byte
      seg = '{8'h62, htsr_pkg::CHAR_GT, 8'hFF, htsr_pkg::CHAR_LT};
      send_segment(seg, 1'b0);
      // zero byte cannot start a name
      seg = '{8'h00};
      send_segment(seg, 1'b0);

      // --- random segments ----------------------------------------------
      seg_count = 0;
      while (sent_items < RANDOM_ITEMS) begin
         quiet = ($urandom_range(0, 5) == 0);
         // stall the receiver for a long stretch while bytes keep coming
         if (seg_count == 40) long_hold_req = 1'b1;
         // later, hold the sender until every summary has drained
         if (seg_count == 80) begin
            req_bus.valid <= 1'b0;
            @(posedge clock);
            while (tracker.expected_summaries.size() != 0) @(posedge clock);
         end
         kind = $urandom_range(0, 19);
         seg  = build_tag();
         if (kind >= 18) begin
            // noise
            seg.delete();
            n = $urandom_range(0, 6);
            repeat (n) seg.push_back(8'($urandom));
            if (n > 0 && $urandom_range(0, 1)) seg[0] = near_letters[$urandom_range(0, 5)];
         end else if (kind >= 16) begin
            // one corrupted byte
            seg[$urandom_range(0, seg.size() - 1)] =
               $urandom_range(0, 1) ? htsr_pkg::CHAR_LT : 8'($urandom);
         end else if (kind >= 14) begin
            // truncated
            n = $urandom_range(1, seg.size());
            repeat (n) void'(seg.pop_back());
         end
         send_segment(seg, $urandom_range(0, 5) == 0);
         seg_count++;
      end

      // --- drain ------------------------------------------------------------
      req_bus.valid <= 1'b0;
      while (tracker.expected_summaries.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (tracker.errors == 0) begin
         $display("** html_tag_segment_recognizer: PASSED **");
      end else begin
         $display("** html_tag_segment_recognizer: FAILED **");
      end
      $finish;
   end

endmodule

@@ files.f @@
hdl/htsr_pkg.sv
hdl/htsr_req_if.sv
hdl/htsr_rsp_if.sv
hdl/htsr_step.sv
hdl/html_tag_segment_recognizer.sv
verif/html_tag_segment_recognizer_test.sv
